/* sv/abte_pkg.sv */
// ----------------------------------------------------------------------------
// abte_pkg
// shared types and constants of the array binary tree engine
// ----------------------------------------------------------------------------
package abte_pkg;

    localparam int NODES_DEF   = 31;
    localparam int MAX_RESULTS = 31;
    localparam int DATA_W      = 8;
    // heap index wide enough for 2i+1 with up to 255 nodes
    localparam int IDX_W       = 9;

    typedef enum logic [2:0] {
        ACT_SEARCH   = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_SET_ROOT = 3'd3,
        ACT_TRAVERSE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ORD_IN   = 2'd0,
        ORD_PRE  = 2'd1,
        ORD_POST = 2'd2,
        ORD_NONE = 2'd3
    } order_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BOTH_TAKEN = 3'd2,
        ST_CHILD_NA  = 3'd3,
        ST_NOT_LEAF  = 3'd4,
        ST_ROOT_OCC  = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } store_req_t;

endpackage

/* sv/array_binary_tree_engine.sv */
// ----------------------------------------------------------------------------
// array_binary_tree_engine
// heap-indexed binary tree: search, insert, delete, set root and traversal
// ----------------------------------------------------------------------------
//  channel | ports                                        | role
//  s_      | action, key, item, side, order               | command in
//  m_      | status, node_index, node_value, last         | results out
//
//  one command at a time; s_ready is high only while the sequencer is idle
//  search reads and then compares each index visited, and climbs in a separate step
//  a traversal reads and checks each node on the way down and again on the way back up
//  reset (synchronous, active low) empties the store at once via valid bits
//  a stalled result transfer holds the sequencer until m_ready
// ----------------------------------------------------------------------------
module array_binary_tree_engine #(
    parameter int NODES = abte_pkg::NODES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_key,
    input  logic [7:0] s_item,
    input  logic       s_side,
    input  logic [1:0] s_order,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [4:0] m_node_index,
    output logic [7:0] m_node_value,
    output logic       m_last
);
    import abte_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] N_I = IDX_W'(NODES);
    localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

    typedef enum logic [3:0] {
        IDLE, SCAN_RD, SCAN_CMP, SCAN_UP, CH_L, CH_LCHK, CH_RCHK, EVAL,
        ROOT_RD, ROOT_CHK, W_DOWN, W_DCHK, W_UP, W_UCHK, FLUSH
    } state_t;

    state_t             state_reg;
    action_t            act_reg;
    order_t             ord_reg;
    logic [DATA_W-1:0]  key_reg, item_reg, val_reg;
    logic               side_reg, occ_l_reg, occ_r_reg;
    logic [IDX_W-1:0]   i_reg, l_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               pend_v_reg;
    status_t            pend_st_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic [DATA_W-1:0]  pend_val_reg;
    logic               m_valid_reg, m_last_reg;
    logic [2:0]         m_status_reg;
    logic [4:0]         m_idx_reg;
    logic [7:0]         m_val_reg;

    store_req_t         req;
    logic [DATA_W-1:0]  rdata;
    logic [IDX_W-1:0]   dbl_i, dbl_l, par_i, child;
    logic               out_free, want_emit, emit_go, ch_occ, m_load;
    logic [IDX_W-1:0]   emit_idx;
    logic [CNT_W-1:0]   cnt_inc;

    abte_store #(.NODES(NODES)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rdata)
    );

    assign dbl_i    = {i_reg[IDX_W-2:0], 1'b0};
    assign dbl_l    = {l_reg[IDX_W-2:0], 1'b0};
    assign par_i    = i_reg >> 1;
    assign child    = dbl_l | IDX_W'(side_reg);
    assign ch_occ   = side_reg ? occ_r_reg : occ_l_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    always_comb begin
        want_emit = 1'b0;
        emit_idx  = i_reg;
        case (state_reg)
            W_DCHK: begin
                want_emit = (rdata != '0) && (ord_reg == ORD_PRE);
            end
            W_UCHK: begin
                emit_idx  = par_i;
                want_emit = i_reg[0] ? (ord_reg == ORD_POST) : (ord_reg == ORD_IN);
            end
            default: ;
        endcase
        emit_go = !want_emit || !pend_v_reg || out_free;
    end

    // output register is loaded this cycle
    assign m_load = (want_emit && emit_go && pend_v_reg) || (state_reg == FLUSH && out_free);

    always_comb begin
        req = '0;
        case (state_reg)
            SCAN_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = i_reg;
            end
            CH_L: begin
                req.rd_en   = (dbl_l <= N_I);
                req.rd_addr = dbl_l;
            end
            CH_LCHK: begin
                req.rd_en   = ((dbl_l | ONE) <= N_I);
                req.rd_addr = dbl_l | ONE;
            end
            ROOT_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = ONE;
            end
            W_DOWN: begin
                req.rd_en   = (i_reg <= N_I);
                req.rd_addr = i_reg;
            end
            W_UP: begin
                req.rd_en   = (par_i != '0);
                req.rd_addr = par_i;
            end
            EVAL: begin
                if (act_reg == ACT_INSERT) begin
                    req.wr_en   = !(occ_l_reg && occ_r_reg) && (child <= N_I) && !ch_occ;
                    req.wr_addr = child;
                    req.wr_data = item_reg;
                end else begin
                    req.wr_en   = !(occ_l_reg || occ_r_reg);
                    req.wr_addr = l_reg;
                    req.wr_data = '0;
                end
            end
            ROOT_CHK: begin
                req.wr_en   = (act_reg == ACT_SET_ROOT) && (rdata == '0);
                req.wr_addr = ONE;
                req.wr_data = item_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            // traversal result goes to pending; older pending goes out
            if (want_emit && emit_go) begin
                if (pend_v_reg) begin
                    m_valid_reg  <= 1'b1;
                    m_last_reg   <= 1'b0;
                    m_status_reg <= pend_st_reg;
                    m_idx_reg    <= pend_idx_reg[4:0];
                    m_val_reg    <= pend_val_reg;
                end
                pend_v_reg   <= 1'b1;
                pend_st_reg  <= ST_OK;
                pend_idx_reg <= emit_idx;
                pend_val_reg <= rdata;
                cnt_reg      <= cnt_inc;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        act_reg  <= action_t'(s_action);
                        ord_reg  <= order_t'(s_order);
                        key_reg  <= s_key;
                        item_reg <= s_item;
                        side_reg <= s_side;
                        i_reg    <= ONE;
                        case (action_t'(s_action))
                            ACT_SEARCH, ACT_INSERT, ACT_DELETE: state_reg <= SCAN_RD;
                            ACT_SET_ROOT, ACT_TRAVERSE:          state_reg <= ROOT_RD;
                            default:                             state_reg <= IDLE;
                        endcase
                    end
                end
                SCAN_RD: state_reg <= SCAN_CMP;
                SCAN_CMP: begin
                    if (rdata == key_reg) begin
                        l_reg   <= i_reg;
                        val_reg <= rdata;
                        if (act_reg == ACT_SEARCH) begin
                            pend_st_reg  <= ST_OK;
                            pend_idx_reg <= i_reg;
                            pend_val_reg <= rdata;
                            state_reg    <= FLUSH;
                        end else begin
                            state_reg <= CH_L;
                        end
                    end else if (dbl_i <= N_I) begin
                        i_reg     <= dbl_i;
                        state_reg <= SCAN_RD;
                    end else begin
                        state_reg <= SCAN_UP;
                    end
                end
                SCAN_UP: begin
                    if (i_reg[0] || i_reg == N_I) begin
                        i_reg <= par_i;
                        if (par_i == '0) begin
                            pend_st_reg  <= ST_NOT_FOUND;
                            pend_idx_reg <= '0;
                            pend_val_reg <= '0;
                            state_reg    <= FLUSH;
                        end
                    end else begin
                        i_reg     <= i_reg + ONE;
                        state_reg <= SCAN_RD;
                    end
                end
                CH_L: begin
                    if (dbl_l <= N_I) begin
                        state_reg <= CH_LCHK;
                    end else begin
                        occ_l_reg <= 1'b0;
                        occ_r_reg <= 1'b0;
                        state_reg <= EVAL;
                    end
                end
                CH_LCHK: begin
                    occ_l_reg <= (rdata != '0);
                    if ((dbl_l | ONE) <= N_I) begin
                        state_reg <= CH_RCHK;
                    end else begin
                        occ_r_reg <= 1'b0;
                        state_reg <= EVAL;
                    end
                end
                CH_RCHK: begin
                    occ_r_reg <= (rdata != '0);
                    state_reg <= EVAL;
                end
                EVAL: begin
                    pend_idx_reg <= '0;
                    pend_val_reg <= '0;
                    if (act_reg == ACT_INSERT) begin
                        if (occ_l_reg && occ_r_reg) begin
                            pend_st_reg <= ST_BOTH_TAKEN;
                        end else if (child > N_I || ch_occ) begin
                            pend_st_reg <= ST_CHILD_NA;
                        end else begin
                            pend_st_reg  <= ST_OK;
                            pend_idx_reg <= child;
                            pend_val_reg <= item_reg;
                        end
                    end else begin
                        if (occ_l_reg || occ_r_reg) begin
                            pend_st_reg <= ST_NOT_LEAF;
                        end else begin
                            pend_st_reg  <= ST_OK;
                            pend_idx_reg <= l_reg;
                            pend_val_reg <= val_reg;
                        end
                    end
                    state_reg <= FLUSH;
                end
                ROOT_RD: state_reg <= ROOT_CHK;
                ROOT_CHK: begin
                    pend_idx_reg <= '0;
                    pend_val_reg <= '0;
                    state_reg    <= FLUSH;
                    if (act_reg == ACT_SET_ROOT) begin
                        if (rdata != '0) begin
                            pend_st_reg <= ST_ROOT_OCC;
                        end else begin
                            pend_st_reg  <= ST_OK;
                            pend_idx_reg <= ONE;
                            pend_val_reg <= item_reg;
                        end
                    end else if (rdata == '0) begin
                        pend_st_reg <= ST_EMPTY;
                    end else if (ord_reg == ORD_NONE) begin
                        pend_st_reg <= ST_OK;
                    end else begin
                        pend_v_reg <= 1'b0;
                        cnt_reg    <= '0;
                        i_reg      <= ONE;
                        state_reg  <= W_DOWN;
                    end
                end
                W_DOWN: state_reg <= (i_reg <= N_I) ? W_DCHK : W_UP;
                W_DCHK: begin
                    if (rdata == '0) begin
                        state_reg <= W_UP;
                    end else if (emit_go) begin
                        i_reg     <= dbl_i;
                        state_reg <= (want_emit && cnt_inc == CNT_W'(MAX_RESULTS)) ?
                                     FLUSH : W_DOWN;
                    end
                end
                W_UP: state_reg <= (par_i == '0) ? FLUSH : W_UCHK;
                W_UCHK: begin
                    if (emit_go) begin
                        if (want_emit && cnt_inc == CNT_W'(MAX_RESULTS)) begin
                            state_reg <= FLUSH;
                        end else if (!i_reg[0]) begin
                            i_reg     <= {par_i[IDX_W-2:0], 1'b1};
                            state_reg <= W_DOWN;
                        end else begin
                            i_reg     <= par_i;
                            state_reg <= W_UP;
                        end
                    end
                end
                FLUSH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_last_reg   <= 1'b1;
                        m_status_reg <= pend_st_reg;
                        m_idx_reg    <= pend_idx_reg[4:0];
                        m_val_reg    <= pend_val_reg;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_node_index = m_idx_reg;
    assign m_node_value = m_val_reg;
    assign m_last       = m_last_reg;

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> (req.wr_addr != '0) && (req.wr_addr <= N_I))
        else $error("store write outside the tree");

    a_rd_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.rd_en && req.wr_en))
        else $error("store read and write in the same cycle");

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("traversal result count overflow");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action <= ACT_TRAVERSE)) |=> !s_ready)
        else $error("new command taken while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_node_index) && $stable(m_last))
        else $error("pending result transfer overwritten");

endmodule

/* sv/abte_ram.sv */
// ----------------------------------------------------------------------------
// abte_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module abte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/abte_store.sv */
// ----------------------------------------------------------------------------
// abte_store
// node store: ram plus per-slot valid bits so that reset empties every slot
// ----------------------------------------------------------------------------
module abte_store #(
    parameter int NODES = abte_pkg::NODES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  abte_pkg::store_req_t        req,
    output logic [abte_pkg::DATA_W-1:0] rd_data
);
    import abte_pkg::*;

    localparam int DEPTH = NODES + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [DEPTH-1:0]  valid_reg;
    logic              vld_q_reg;
    logic [DATA_W-1:0] ram_q;

    abte_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (req.wr_en),
        .waddr (req.wr_addr[AW-1:0]),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr[AW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en) begin
                vld_q_reg <= valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    // never written slot reads as empty
    assign rd_data = vld_q_reg ? ram_q : '0;

endmodule

/* dv/array_binary_tree_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_engine_checker
// watches both channels, keeps a shadow copy of the tree store, predicts the
// results of every accepted command and compares them with the result stream
// ----------------------------------------------------------------------------
module array_binary_tree_engine_checker #(
    parameter int NODES = abte_pkg::NODES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_key,
    input  logic [7:0] s_item,
    input  logic       s_side,
    input  logic [1:0] s_order,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_status,
    input  logic [4:0] m_node_index,
    input  logic [7:0] m_node_value,
    input  logic       m_last,
    output int         fail_count,
    output int         pending,
    output int         result_count
);
    import abte_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] node_index;
        logic [7:0] node_value;
        logic       last;
    } tree_result_t;

    logic [7:0]   tree_mem [0:NODES];
    tree_result_t result_q[$];
    int           walk_count;

    function automatic bit slot_used(int i);
        return i <= NODES && tree_mem[i] != 0;
    endfunction

    function automatic int locate_key(int i, logic [7:0] k);
        int x;
        x = 0;
        if (i > NODES) return 0;
        if (tree_mem[i] == k) return i;
        if (2 * i <= NODES) x = locate_key(2 * i, k);
        else return 0;
        if (x == 0 && 2 * i + 1 <= NODES) x = locate_key(2 * i + 1, k);
        return x;
    endfunction

    task automatic push_result(status_t st, int idx, logic [7:0] val);
        tree_result_t r;
        r.status     = st;
        r.node_index = idx[4:0];
        r.node_value = val;
        r.last       = 1'b0;
        result_q.push_back(r);
    endtask

    task automatic walk_tree(int i, order_t o);
        if (!slot_used(i)) return;
        if (o == ORD_PRE && walk_count < MAX_RESULTS) begin
            push_result(ST_OK, i, tree_mem[i]);
            walk_count++;
        end
        walk_tree(2 * i, o);
        if (o == ORD_IN && walk_count < MAX_RESULTS) begin
            push_result(ST_OK, i, tree_mem[i]);
            walk_count++;
        end
        walk_tree(2 * i + 1, o);
        if (o == ORD_POST && walk_count < MAX_RESULTS) begin
            push_result(ST_OK, i, tree_mem[i]);
            walk_count++;
        end
    endtask

    task automatic predict_command(logic [2:0] act, logic [7:0] k, logic [7:0] itm,
                                   logic sd, logic [1:0] ord);
        int         loc;
        int         ch;
        logic [7:0] v;
        if (act > ACT_TRAVERSE) return;
        case (action_t'(act))
            ACT_SEARCH: begin
                loc = locate_key(1, k);
                if (loc == 0) push_result(ST_NOT_FOUND, 0, 0);
                else push_result(ST_OK, loc, tree_mem[loc]);
            end
            ACT_INSERT: begin
                loc = locate_key(1, k);
                ch  = 2 * loc + sd;
                if (loc == 0) push_result(ST_NOT_FOUND, 0, 0);
                else if (slot_used(2 * loc) && slot_used(2 * loc + 1))
                    push_result(ST_BOTH_TAKEN, 0, 0);
                else if (ch > NODES || tree_mem[ch] != 0) push_result(ST_CHILD_NA, 0, 0);
                else begin
                    tree_mem[ch] = itm;
                    push_result(ST_OK, ch, itm);
                end
            end
            ACT_DELETE: begin
                loc = locate_key(1, k);
                if (loc == 0) push_result(ST_NOT_FOUND, 0, 0);
                else if (slot_used(2 * loc) || slot_used(2 * loc + 1))
                    push_result(ST_NOT_LEAF, 0, 0);
                else begin
                    v = tree_mem[loc];
                    tree_mem[loc] = 0;
                    push_result(ST_OK, loc, v);
                end
            end
            ACT_SET_ROOT: begin
                if (tree_mem[1] != 0) push_result(ST_ROOT_OCC, 0, 0);
                else begin
                    tree_mem[1] = itm;
                    push_result(ST_OK, 1, itm);
                end
            end
            default: begin
                if (tree_mem[1] == 0) push_result(ST_EMPTY, 0, 0);
                else if (ord == ORD_NONE) push_result(ST_OK, 0, 0);
                else begin
                    walk_count = 0;
                    walk_tree(1, order_t'(ord));
                end
            end
        endcase
        result_q[$].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        tree_result_t want;
        if (!aresetn) begin
            for (int i = 0; i <= NODES; i++) tree_mem[i] = 0;
            result_q.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: st %0d idx %0d val %0d",
                                 m_status, m_node_index, m_node_value);
                end else begin
                    want = result_q.pop_front();
                    if (want !== {m_status, m_node_index, m_node_value, m_last}) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected st %0d idx %0d val %0d last %0b,",
                                      " got st %0d idx %0d val %0d last %0b"},
                                     want.status, want.node_index, want.node_value,
                                     want.last, m_status, m_node_index, m_node_value,
                                     m_last);
                    end
                end
            end
            if (s_valid && s_ready)
                predict_command(s_action, s_key, s_item, s_side, s_order);
        end
        pending = result_q.size();
    end

endmodule

/* dv/array_binary_tree_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_engine_tb
// directed and random command streams for the tree engine, with random
// gaps on the command side and random stalls on the result side
// ----------------------------------------------------------------------------
module array_binary_tree_engine_tb;
    import abte_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_action;
    logic [7:0] s_key;
    logic [7:0] s_item;
    logic       s_side;
    logic [1:0] s_order;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [4:0] m_node_index;
    logic [7:0] m_node_value;
    logic       m_last;
    int         fail_count;
    int         pending;
    int         result_count;
    int         cmd_count;
    logic [7:0] known_vals[$];

    array_binary_tree_engine u_top (.*);

    array_binary_tree_engine_checker u_checker (.*);

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 3) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_cmd(logic [2:0] act, logic [7:0] k, logic [7:0] itm,
                            logic sd, logic [1:0] ord);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_key    <= k;
        s_item   <= itm;
        s_side   <= sd;
        s_order  <= ord;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cmd_count++;
        if (act == ACT_INSERT || act == ACT_SET_ROOT) known_vals.push_back(itm);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_key();
        if (known_vals.size() > 0 && $urandom_range(0, 9) < 8)
            return known_vals[$urandom_range(0, known_vals.size() - 1)];
        return 8'($urandom);
    endfunction

    always @(negedge aclk) begin
        if ($urandom_range(0, 39) == 0) m_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_ready <= ~m_ready;
    end

    initial begin
        #3000000;
        $display("[array_binary_tree_engine] ERROR");
        $finish;
    end

    initial begin
        int act;
        int w;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_action  = '0;
        s_key     = '0;
        s_item    = '0;
        s_side    = 1'b0;
        s_order   = '0;
        m_ready   = 1'b1;
        cmd_count = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty tree, root, children, extremes, every order
        send_cmd(ACT_TRAVERSE, 0, 0, 0, ORD_IN);
        send_cmd(ACT_SEARCH, 8'h00, 0, 0, 0);
        send_cmd(ACT_SEARCH, 8'hff, 0, 0, 0);
        send_cmd(ACT_DELETE, 8'h11, 0, 0, 0);
        send_cmd(ACT_SET_ROOT, 0, 8'hff, 0, 0);
        send_cmd(ACT_SET_ROOT, 0, 8'h01, 0, 0);
        send_cmd(ACT_INSERT, 8'hff, 8'h80, 0, 0);
        send_cmd(ACT_INSERT, 8'hff, 8'h7f, 1, 0);
        send_cmd(ACT_INSERT, 8'hff, 8'h22, 1, 0);
        send_cmd(ACT_INSERT, 8'h80, 8'h00, 0, 0);
        send_cmd(ACT_INSERT, 8'h55, 8'h33, 0, 0);
        send_cmd(ACT_SEARCH, 8'h00, 0, 0, 0);
        send_cmd(ACT_SEARCH, 8'h7f, 0, 0, 0);
        send_cmd(ACT_TRAVERSE, 0, 0, 0, ORD_IN);
        send_cmd(ACT_TRAVERSE, 0, 0, 0, ORD_PRE);
        send_cmd(ACT_TRAVERSE, 0, 0, 0, ORD_POST);
        send_cmd(ACT_TRAVERSE, 0, 0, 0, ORD_NONE);
        send_cmd(ACT_DELETE, 8'hff, 0, 0, 0);
        send_cmd(ACT_DELETE, 8'h80, 0, 0, 0);
        send_cmd(3'd5, 8'hff, 8'hff, 1, 2'd3);
        send_cmd(3'd7, 8'h00, 8'h00, 0, 0);

        // random: inserts most often, mostly on known keys, to grow deep trees
        repeat (480) begin
            w = $urandom_range(0, 99);
            if (w < 40) act = ACT_INSERT;
            else if (w < 55) act = ACT_SEARCH;
            else if (w < 70) act = ACT_DELETE;
            else if (w < 78) act = ACT_SET_ROOT;
            else if (w < 96) act = ACT_TRAVERSE;
            else act = $urandom_range(5, 7);
            send_cmd(3'(act), pick_key(), 8'($urandom), 1'($urandom),
                     2'($urandom));
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("commands sent: %0d, result transfers checked: %0d",
                 cmd_count, result_count);
        if (fail_count == 0)
            $display("[array_binary_tree_engine] OK");
        else
            $display("[array_binary_tree_engine] ERROR");
        $finish;
    end

endmodule
